@@ rtl/mf3_pkg.sv @@
// Shared types, constants and the compare-exchange helper for the 3x3 median filter.
// No dependencies; used by every module of the filter except mf3_ram.
package mf3_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 13;
  localparam int WIN_N          = 9;
  localparam int COL_N          = 3;
  localparam int MAX_WIDTH_DFLT = 4096;
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 13'd640;

  typedef logic [PIX_W-1:0]            pix_t;
  typedef logic [COL_N-1:0][PIX_W-1:0] col_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;
  typedef logic [3:0]                  win_idx_t;

  // Control that travels alongside a window through the sorting stages.
  typedef struct packed {
    logic valid;
    logic full;
  } pipe_ctl_t;

  // One compare-exchange: the smaller value ends up at lo, the larger at hi.
  function automatic win_t ce(win_t w, win_idx_t lo, win_idx_t hi);
    win_t r;
    r = w;
    if (w[lo] > w[hi]) begin
      r[lo] = w[hi];
      r[hi] = w[lo];
    end
    return r;
  endfunction

endpackage

@@ rtl/mf3_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mf3_col_cell.sv @@
// One column cell of the 3x3 window: holds three pixels and takes a new column
// from its neighbor on each shift. Depends on mf3_pkg.
module mf3_col_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  mf3_pkg::col_t col_in,
  output mf3_pkg::col_t col_q
);

  mf3_pkg::col_t col_r;
  mf3_pkg::col_t col_nxt;

  always_comb begin
    col_nxt = shift ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_q = col_r;

endmodule

@@ rtl/mf3_median.sv @@
// Pipelined median-of-nine sorting network: nine compare-exchange layers in
// three registered stages. Depends on mf3_pkg.
module mf3_median (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  mf3_pkg::pipe_ctl_t  in_ctl,
  input  mf3_pkg::win_t       in_win,
  output mf3_pkg::pipe_ctl_t  out_ctl,
  output mf3_pkg::pix_t       out_med
);

  mf3_pkg::win_t      s1_r, s2_r, s3_r;
  mf3_pkg::win_t      s1_nxt, s2_nxt, s3_nxt;
  mf3_pkg::pipe_ctl_t c1_r, c2_r, c3_r;

  // Layers one to three sort each row.
  always_comb begin
    s1_nxt = in_win;
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd1, 4'd2);
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd4, 4'd5);
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd7, 4'd8);
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd0, 4'd1);
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd3, 4'd4);
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd6, 4'd7);
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd1, 4'd2);
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd4, 4'd5);
    s1_nxt = mf3_pkg::ce(s1_nxt, 4'd7, 4'd8);
  end

  // Layers four to six work across the sorted rows.
  always_comb begin
    s2_nxt = s1_r;
    s2_nxt = mf3_pkg::ce(s2_nxt, 4'd0, 4'd3);
    s2_nxt = mf3_pkg::ce(s2_nxt, 4'd5, 4'd8);
    s2_nxt = mf3_pkg::ce(s2_nxt, 4'd4, 4'd7);
    s2_nxt = mf3_pkg::ce(s2_nxt, 4'd3, 4'd6);
    s2_nxt = mf3_pkg::ce(s2_nxt, 4'd1, 4'd4);
    s2_nxt = mf3_pkg::ce(s2_nxt, 4'd2, 4'd5);
    s2_nxt = mf3_pkg::ce(s2_nxt, 4'd4, 4'd7);
  end

  // The last layers settle the middle element.
  always_comb begin
    s3_nxt = s2_r;
    s3_nxt = mf3_pkg::ce(s3_nxt, 4'd4, 4'd2);
    s3_nxt = mf3_pkg::ce(s3_nxt, 4'd6, 4'd4);
    s3_nxt = mf3_pkg::ce(s3_nxt, 4'd4, 4'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign out_ctl = c3_r;
  assign out_med = s3_r[4];

endmodule

@@ rtl/median_filter_3x3_unit.sv @@
// Top level of the 3x3 median filter: counters, line store, window cells,
// sorting pipeline and output skid stage. Depends on mf3_pkg, mf3_ram,
// mf3_col_cell and mf3_median.

// The filter takes one 8-bit pixel per clock in raster order while in_stall
// is low and returns one result per pixel: the median of the 3x3 window whose
// bottom-right corner is that pixel, with window_full set when the window lies
// wholly inside the frame (the window's center is then at row-1, column-1);
// otherwise the value is zero. It sustains one request per cycle unless
// in_stall is high. A result passes through the line-store read, which
// completes at the accepting edge, then the window column cells, the three
// sorting-network stages and the output register. The two previous rows
// live in one RAM of MAX_WIDTH entries, 16 bits wide, read and rewritten
// once per pixel.
// cfg_wdata sets the line width; values below 3 act as 3 and values above
// MAX_WIDTH act as MAX_WIDTH. Write it only while the filter is idle.
// in_frame_start restarts the row and column counters on its pixel.
module median_filter_3x3_unit #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DFLT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mf3_pkg::pix_t             in_pixel,
  input  logic                      in_frame_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mf3_pkg::pix_t             out_median_value,
  output logic                      out_window_full
);

  localparam int AW = $clog2(MAX_WIDTH);
  // Wide enough for both the configured width and MAX_WIDTH itself.
  localparam int EW = (AW + 1 > mf3_pkg::CFG_W + 1) ? AW + 1 : mf3_pkg::CFG_W + 1;
  localparam int LW = 2 * mf3_pkg::PIX_W;
  localparam logic [1:0] ROW_FULL = 2'd2;

  // Configuration and position counters.
  logic [mf3_pkg::CFG_W-1:0] line_width_r;
  logic [AW-1:0]             col_cnt_r, col_cnt_nxt;
  logic [1:0]                row_cnt_r, row_cnt_nxt;

  logic [EW-1:0] width_raw;
  logic [EW-1:0] width_eff;
  logic [EW-1:0] col_plus;
  logic [AW-1:0] col_cur;
  logic [1:0]    row_cur;
  logic          row_end;
  logic          full_cur;

  logic en;
  logic accept;

  // Stage one: line-store data arrives.
  logic          v1_r;
  logic [AW-1:0] col1_r;
  mf3_pkg::pix_t px1_r;
  logic          full1_r;
  logic          fwd_hit_r;
  logic [LW-1:0] fwd_data_r;

  logic [LW-1:0] ls_rdata;
  logic [LW-1:0] ls_wdata;
  logic          ls_we;
  mf3_pkg::pix_t row_above;
  mf3_pkg::pix_t row_above2;

  // Window cells and sorter.
  mf3_pkg::col_t      new_col;
  mf3_pkg::col_t      cell_q [mf3_pkg::COL_N];
  mf3_pkg::win_t      win;
  mf3_pkg::pipe_ctl_t ctl2_r;
  mf3_pkg::pipe_ctl_t med_ctl;
  mf3_pkg::pix_t      med_val;
  logic               emit;
  mf3_pkg::pix_t      emit_val;

  // Output register and skid stage.
  logic          out_valid_r;
  mf3_pkg::pix_t out_val_r;
  logic          out_full_r;
  logic          skid_full_r;
  mf3_pkg::pix_t skid_val_r;
  logic          skid_full_flag_r;

  // The whole pipeline advances together unless the skid stage is holding a
  // result; a result emitted while the output waits lands in the skid.
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= mf3_pkg::LINE_WIDTH_RST;
    end else if (cfg_we) begin
      line_width_r <= cfg_wdata;
    end
  end

  // Clamp the configured width into the supported range.
  always_comb begin
    width_raw = EW'(line_width_r);
    if (width_raw < EW'(3)) begin
      width_eff = EW'(3);
    end else if (width_raw > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
  end

  // A frame start restarts the position before this pixel is placed.
  always_comb begin
    col_cur  = in_frame_start ? '0 : col_cnt_r;
    row_cur  = in_frame_start ? '0 : row_cnt_r;
    col_plus = EW'(col_cur) + EW'(1);
    row_end  = col_plus >= width_eff;
    full_cur = (row_cur == ROW_FULL) && (col_cur >= AW'(2));
    if (row_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_cur == ROW_FULL) ? row_cur : row_cur + 2'd1;
    end else begin
      col_cnt_nxt = col_plus[AW-1:0];
      row_cnt_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Each line-store entry holds the previous row's pixel in the upper byte
  // and the pixel of the row before that in the lower byte.
  mf3_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ls_we),
    .waddr(col1_r),
    .wdata(ls_wdata),
    .re   (accept),
    .raddr(col_cur),
    .rdata(ls_rdata)
  );

  // When a read was issued in the same cycle as the write to that column,
  // the RAM returned stale data, so the written value is forwarded instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col1_r     <= col_cur;
      px1_r      <= in_pixel;
      full1_r    <= full_cur;
      fwd_hit_r  <= ls_we && (col1_r == col_cur);
      fwd_data_r <= ls_wdata;
    end
  end

  always_comb begin
    row_above  = fwd_hit_r ? fwd_data_r[LW-1:mf3_pkg::PIX_W]
                           : ls_rdata[LW-1:mf3_pkg::PIX_W];
    row_above2 = fwd_hit_r ? fwd_data_r[mf3_pkg::PIX_W-1:0]
                           : ls_rdata[mf3_pkg::PIX_W-1:0];
    ls_we      = v1_r && en;
    ls_wdata   = {px1_r, row_above};
    new_col[0] = row_above2;
    new_col[1] = row_above;
    new_col[2] = px1_r;
  end

  // Chain of column cells: the newest column enters the rightmost cell and
  // each cell hands its column to the left neighbor on every shift.
  for (genvar c = 0; c < mf3_pkg::COL_N; c++) begin : g_cells
    mf3_col_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ls_we),
      .col_in((c == mf3_pkg::COL_N - 1) ? new_col : cell_q[(c + 1) % mf3_pkg::COL_N]),
      .col_q (cell_q[c])
    );
  end

  // Row-major window: index row*3+column, column 0 being the oldest.
  always_comb begin
    for (int r = 0; r < mf3_pkg::COL_N; r++) begin
      for (int c = 0; c < mf3_pkg::COL_N; c++) begin
        win[r * mf3_pkg::COL_N + c] = cell_q[c][r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r.valid <= v1_r;
      ctl2_r.full  <= full1_r;
    end
  end

  mf3_median u_median (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_ctl (ctl2_r),
    .in_win (win),
    .out_ctl(med_ctl),
    .out_med(med_val)
  );

  assign emit     = med_ctl.valid && en;
  assign emit_val = med_ctl.full ? med_val : '0;

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      if (emit) begin
        skid_full_r <= 1'b1;
      end
    end else if (skid_full_r) begin
      out_valid_r <= 1'b1;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (emit) begin
        skid_val_r       <= emit_val;
        skid_full_flag_r <= med_ctl.full;
      end
    end else if (skid_full_r) begin
      out_val_r  <= skid_val_r;
      out_full_r <= skid_full_flag_r;
    end else if (emit) begin
      out_val_r  <= emit_val;
      out_full_r <= med_ctl.full;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_val_r;
  assign out_window_full  = out_full_r;

endmodule

@@ tb/median_filter_3x3_unit_tb.sv @@
// Self-checking testbench for the 3x3 median filter unit.
// Depends on mf3_pkg and median_filter_3x3_unit; carries its own line-store
// and window predictor and checks every result against it in order.
`timescale 1ns / 1ps

module median_filter_3x3_unit_tb;

  localparam int LIMIT_CYCLES = 500_000;
  localparam int MAX_SHOWN    = 10;

  typedef logic [mf3_pkg::CFG_W-1:0] cfg_word_t;

  // Pixel patterns used by the random frames.
  typedef enum int {
    PIX_UNIFORM,
    PIX_EXTREME,
    PIX_NARROW,
    PIX_SPIKES
  } pix_style_e;

  // One predicted result: median of the window and the inside-the-frame flag.
  typedef struct packed {
    mf3_pkg::pix_t median;
    logic          full;
  } median_result_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  cfg_word_t     cfg_wdata;
  logic          in_valid;
  logic          in_stall;
  mf3_pkg::pix_t in_pixel;
  logic          in_frame_start;
  logic          out_valid;
  logic          out_stall = 1'b0;
  mf3_pkg::pix_t out_median_value;
  logic          out_window_full;

  median_filter_3x3_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_value (out_median_value),
    .out_window_full  (out_window_full)
  );

  // Results predicted at request acceptance, oldest first.
  median_result_t pending_medians [$];
  int mismatch_count = 0;
  int pixels_sent    = 0;

  // Chance in percent that the sender or the receiver idles in a cycle.
  int in_gap_pct  = 0;
  int out_gap_pct = 0;
  // Cycles for which the receiver holds off no matter what.
  int hold_cycles = 0;

  // Predictor state: the two rows above the current one, the 3x3 window
  // (row-major, newest column on the right), the position in the frame and
  // the programmed line width.
  mf3_pkg::pix_t prev_row  [mf3_pkg::MAX_WIDTH_DFLT];
  mf3_pkg::pix_t prev_row2 [mf3_pkg::MAX_WIDTH_DFLT];
  mf3_pkg::pix_t win_cells [mf3_pkg::WIN_N];
  int unsigned   col_pos;
  int unsigned   row_pos;
  cfg_word_t     line_width_q;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a correct run ends far earlier than this.
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("TB_ERROR");
    $finish;
  end

  // Widths below three act as three, widths above the line store's depth
  // act as the depth.
  function automatic int unsigned eff_width(cfg_word_t w);
    if (w < 3) return 3;
    if (w > mf3_pkg::MAX_WIDTH_DFLT) return mf3_pkg::MAX_WIDTH_DFLT;
    return int'(w);
  endfunction

  // Fifth smallest of nine, found by a plain insertion sort.
  function automatic mf3_pkg::pix_t median9(input mf3_pkg::pix_t v [mf3_pkg::WIN_N]);
    mf3_pkg::pix_t s [mf3_pkg::WIN_N];
    mf3_pkg::pix_t t;
    int            i;
    int            j;
    s = v;
    for (i = 1; i < mf3_pkg::WIN_N; i++) begin
      j = i;
      while (j > 0 && s[j-1] > s[j]) begin
        t      = s[j];
        s[j]   = s[j-1];
        s[j-1] = t;
        j--;
      end
    end
    return s[4];
  endfunction

  // Advances the predictor by one accepted pixel and returns its result.
  function automatic median_result_t predict_median_step(mf3_pkg::pix_t px, logic fs);
    median_result_t r;
    int unsigned    w;
    int unsigned    c;
    mf3_pkg::pix_t  top;
    mf3_pkg::pix_t  mid;
    int             k;
    w = eff_width(line_width_q);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    if (c >= mf3_pkg::MAX_WIDTH_DFLT) c = 0;
    // The line stores shift down one row at this column.
    top          = prev_row2[c];
    mid          = prev_row[c];
    prev_row2[c] = mid;
    prev_row[c]  = px;
    for (k = 0; k < mf3_pkg::COL_N; k++) begin
      win_cells[k*3]   = win_cells[k*3+1];
      win_cells[k*3+1] = win_cells[k*3+2];
    end
    win_cells[2] = top;
    win_cells[5] = mid;
    win_cells[8] = px;
    r.full   = (row_pos >= 2) && (c >= 2);
    r.median = r.full ? median9(win_cells) : '0;
    // The end-of-row test uses the width in force now, so a column already
    // past a narrowed width ends the row on this pixel.
    if (c + 1 >= w) begin
      col_pos = 0;
      if (row_pos < 2) row_pos++;
    end else begin
      col_pos = c + 1;
    end
    return r;
  endfunction

  function automatic mf3_pkg::pix_t pick_pixel(pix_style_e style, mf3_pkg::pix_t base);
    case (style)
      PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_NARROW:  return mf3_pkg::pix_t'(int'(base) + int'($urandom_range(6)) - 3);
      PIX_SPIKES: begin
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return base;
      end
      default:     return mf3_pkg::pix_t'($urandom_range(255));
    endcase
  endfunction

  task automatic set_gaps(int in_pct, int out_pct);
    in_gap_pct  = in_pct;
    out_gap_pct = out_pct;
  endtask

  // Offers one pixel request and returns once the filter has accepted it.
  // Idle cycles before the request carry junk payload with valid low.
  task automatic send_pixel(input mf3_pkg::pix_t px, input logic fs);
    while ($urandom_range(99) < in_gap_pct) begin
      @(negedge clk);
      in_valid       = 1'b0;
      in_pixel       = mf3_pkg::pix_t'($urandom_range(255));
      in_frame_start = 1'($urandom_range(1));
    end
    @(negedge clk);
    in_valid       = 1'b1;
    in_pixel       = px;
    in_frame_start = fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_medians.push_back(predict_median_step(px, fs));
    pixels_sent++;
  endtask

  // Stops offering requests and waits until every predicted result is back.
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
  endtask

  // Every pixel yields exactly one result, so an empty queue means the
  // filter is idle and the width may be changed.
  task automatic write_line_width(cfg_word_t value);
    wait_drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    line_width_q = value;
  endtask

  task automatic note_mismatch(string what, logic [8:0] want, logic [8:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Receiver: a long hold-off when one is requested, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < out_gap_pct);
    end
  end

  // Every accepted result is compared field by field with the oldest
  // prediction.
  always @(posedge clk) begin : check_results
    median_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        note_mismatch("unrequested result", '0, {1'b0, out_median_value});
      end else begin
        want = pending_medians.pop_front();
        if (out_median_value !== want.median)
          note_mismatch("median_value", {1'b0, want.median}, {1'b0, out_median_value});
        if (out_window_full !== want.full)
          note_mismatch("window_full", {8'd0, want.full}, {8'd0, out_window_full});
      end
    end
  end

  // A uniform window of the bright extreme, windows that turn from all bright
  // to one and then two dark rows, and a frame restart in the middle of a row.
  // The first pixels run at the reset width before any write.
  task automatic test_window_extremes();
    int i;
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b0);
    // Zero is below the minimum and acts as a width of three.
    write_line_width('0);
    for (i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
    for (i = 0; i < 6; i++) send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h7F, 1'b1);
    send_pixel(8'hFE, 1'b0);
  endtask

  // Narrowing the width while the column is already past the new width ends
  // the row on the next pixel; the frame goes on without a restart.
  task automatic test_width_shrink_mid_row();
    int i;
    write_line_width(13'd6);
    for (i = 0; i < 5; i++) send_pixel(mf3_pkg::pix_t'($urandom_range(255)), i == 0);
    write_line_width(13'd3);
    for (i = 0; i < 8; i++) send_pixel(mf3_pkg::pix_t'($urandom_range(255)), 1'b0);
  endtask

  // All-ones in the width register acts as the full line-store depth, so a
  // short stretch of row zero runs on with no row end and zero results.
  task automatic test_widest_row();
    int i;
    write_line_width({mf3_pkg::CFG_W{1'b1}});
    for (i = 0; i < 40; i++)
      send_pixel(mf3_pkg::pix_t'($urandom_range(255)), i == 0);
  endtask

  // The receiver holds off long enough for the filter to fill and stall its
  // input while the sender keeps offering requests; then the sender pauses
  // until every result is back before carrying on.
  task automatic test_output_hold_off();
    int i;
    write_line_width(13'd5);
    hold_cycles = 200;
    for (i = 0; i < 60; i++) send_pixel(mf3_pkg::pix_t'($urandom_range(255)), i == 0);
    wait_drain();
    for (i = 0; i < 15; i++) send_pixel(mf3_pkg::pix_t'($urandom_range(255)), 1'b0);
  endtask

  // Random frames, mostly narrow and a few rows deep so that most pixels see
  // full windows. Wide settings get only a short stretch of row zero. A
  // narrower or equal width may carry on the current frame; a wider one
  // always restarts it so no unwritten line-store entry feeds a result.
  task automatic test_random_frames(int target);
    int            first;
    int            done;
    int            n;
    int            k;
    int            pick;
    cfg_word_t     w;
    int unsigned   new_eff;
    bit            keep_frame;
    pix_style_e    style;
    mf3_pkg::pix_t base;
    first = pixels_sent;
    while (pixels_sent - first < target) begin
      done = pixels_sent - first;
      if (done < target / 3) set_gaps(24, 62);
      else if (done < 2 * target / 3) set_gaps(62, 24);
      else set_gaps(0, 0);
      pick = $urandom_range(99);
      if (pick < 8) w = cfg_word_t'($urandom_range(0, 2));
      else if (pick < 72) w = cfg_word_t'($urandom_range(3, 16));
      else if (pick < 84) w = cfg_word_t'($urandom_range(17, 48));
      else if (pick < 94)
        w = cfg_word_t'($urandom_range(mf3_pkg::MAX_WIDTH_DFLT, (1 << mf3_pkg::CFG_W) - 1));
      else w = cfg_word_t'($urandom_range(49, mf3_pkg::MAX_WIDTH_DFLT - 1));
      new_eff    = eff_width(w);
      keep_frame = (new_eff <= eff_width(line_width_q)) && ($urandom_range(2) == 0);
      write_line_width(w);
      if (new_eff <= 48) n = new_eff * $urandom_range(3, 5) + $urandom_range(0, new_eff - 1);
      else n = $urandom_range(1, 40);
      style = pix_style_e'($urandom_range(3));
      base  = mf3_pkg::pix_t'($urandom_range(255));
      // A rare restart in the middle of a frame is the noise here.
      for (k = 0; k < n; k++)
        send_pixel(pick_pixel(style, base), (k == 0 && !keep_frame) || $urandom_range(249) == 0);
    end
  endtask

  initial begin
    int i;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = mf3_pkg::LINE_WIDTH_RST;
    in_valid       = 1'b0;
    in_pixel       = '0;
    in_frame_start = 1'b0;
    line_width_q   = mf3_pkg::LINE_WIDTH_RST;
    col_pos        = 0;
    row_pos        = 0;
    for (i = 0; i < mf3_pkg::WIN_N; i++) win_cells[i] = '0;
    for (i = 0; i < mf3_pkg::MAX_WIDTH_DFLT; i++) begin
      prev_row[i]  = '0;
      prev_row2[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    set_gaps(24, 62);
    test_window_extremes();
    test_width_shrink_mid_row();
    test_widest_row();
    test_output_hold_off();
    test_random_frames(1550);

    // Let the pipeline run on past the last result so that any extra result
    // shows up as unrequested.
    wait_drain();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_medians.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
